// ===== src/sjrd_pkg.sv =====
// Shared constants, codes and types of the slot job rate divider scheduler.
package sjrd_pkg;

  localparam int unsigned SLOTS  = 32;
  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned PRIO_W = 16;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CHANGE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_NOSLOT = 2'd2
  } stat_e;

  // Classified command handed from the front end to the execution engine.
  typedef struct packed {
    cmd_e              kind;
    logic              in_table;
    logic [IDX_W-1:0]  slot;
    logic [PRIO_W-1:0] prio;
  } cmd_t;

endpackage

// ===== src/sjrd_if.sv =====
// Valid/ready channel interfaces for commands in and results out.
interface sjrd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  slot;
  logic [15:0] priority_req;

  modport source (output valid, kind, slot, priority_req, input ready);
  modport sink   (input valid, kind, slot, priority_req, output ready);
endinterface

interface sjrd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] slot_out;
  logic       fired;
  logic       cpu_busy;
  logic       last;

  modport source (output valid, status, slot_out, fired, cpu_busy, last, input ready);
  modport sink   (input valid, status, slot_out, fired, cpu_busy, last, output ready);
endinterface

// ===== src/sjrd_front.sv =====
// Command front end: decode and range-classify commands, queue them for the engine.
module sjrd_front import sjrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sjrd_in_if.sink     in_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_ready_i
);

  cmd_t              fifo_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;
  cmd_t              cls;

  // Classify: decode the kind and mark slots that lie inside the table.
  always_comb begin
    cls.kind     = cmd_e'(in_i.kind);
    cls.in_table = (in_i.slot < 8'(SLOTS));
    cls.slot     = in_i.slot[IDX_W-1:0];
    cls.prio     = in_i.priority_req;
  end

  assign in_i.ready  = (cnt_q != QCNT_W'(QDEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== src/sjrd_back.sv =====
// Execution engine: slot table, tick and allocation scans, result register.
module sjrd_back import sjrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_ready_o,
  sjrd_out_if.source  out_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TICK = 3'b010,
    S_ADD  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [SLOTS-1:0]  occ_q, occ_d;
  logic [SLOTS-1:0]  zdiv_q, zdiv_d;
  logic [PRIO_W-1:0] div_q [SLOTS];
  logic [PRIO_W-1:0] div_d [SLOTS];
  logic [PRIO_W-1:0] ph_q  [SLOTS];
  logic [PRIO_W-1:0] ph_d  [SLOTS];
  logic [CNT_W-1:0]  hw_q, hw_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [PRIO_W-1:0] prio_q, prio_d;

  logic              ov_q, ov_d;
  logic [1:0]        st_q, st_d;
  logic [4:0]        so_q, so_d;
  logic              fi_q, fi_d, bz_q, bz_d, la_q, la_d;

  logic              can_load, load;
  logic [IDX_W-1:0]  i;
  logic              busy_now, busy_next;

  assign can_load  = !ov_q || out_o.ready;
  assign i         = idx_q[IDX_W-1:0];
  assign busy_now  = |(occ_q & zdiv_q);
  assign busy_next = |(occ_d & zdiv_d);

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    zdiv_d      = zdiv_q;
    div_d       = div_q;
    ph_d        = ph_q;
    hw_d        = hw_q;
    idx_d       = idx_q;
    prio_d      = prio_q;
    cmd_ready_o = 1'b0;
    load        = 1'b0;
    st_d        = STAT_OK;
    so_d        = '0;
    fi_d        = 1'b0;
    bz_d        = busy_now;
    la_d        = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && can_load) begin
          cmd_ready_o = 1'b1;
          idx_d       = '0;
          prio_d      = cmd_i.prio;
          unique case (cmd_i.kind)
            CMD_TICK:  state_d = S_TICK;
            CMD_ADD:   state_d = S_ADD;
            CMD_REMOVE, CMD_CHANGE: begin
              load = 1'b1;
              if (cmd_i.in_table && (CNT_W'(cmd_i.slot) < hw_q)) begin
                ph_d[cmd_i.slot] = '0;
                if (cmd_i.kind == CMD_REMOVE) begin
                  occ_d[cmd_i.slot]  = 1'b0;
                  zdiv_d[cmd_i.slot] = 1'b1;
                  div_d[cmd_i.slot]  = '0;
                  if (CNT_W'(cmd_i.slot) + CNT_W'(1) == hw_q) begin
                    hw_d = hw_q - CNT_W'(1);
                  end
                end else begin
                  zdiv_d[cmd_i.slot] = (cmd_i.prio == '0);
                  div_d[cmd_i.slot]  = cmd_i.prio;
                end
              end else begin
                st_d = STAT_NOSLOT;
              end
              bz_d = busy_next;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_TICK: begin
        if (can_load) begin
          if (idx_q == hw_q) begin
            load    = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + CNT_W'(1);
            if (occ_q[i]) begin
              if (ph_q[i] == '0) begin
                load = 1'b1;
                so_d = 5'(i);
                fi_d = 1'b1;
                la_d = 1'b0;
              end
              ph_d[i] = (ph_q[i] >= div_q[i]) ? '0 : ph_q[i] + PRIO_W'(1);
            end
          end
        end
      end

      S_ADD: begin
        if (can_load) begin
          if ((idx_q == hw_q) && (hw_q == CNT_W'(SLOTS))) begin
            load    = 1'b1;
            st_d    = STAT_FULL;
            state_d = S_IDLE;
          end else if ((idx_q == hw_q) || !occ_q[i]) begin
            occ_d[i]  = 1'b1;
            zdiv_d[i] = (prio_q == '0);
            div_d[i]  = prio_q;
            ph_d[i]   = '0;
            if (idx_q == hw_q) begin
              hw_d = hw_q + CNT_W'(1);
            end
            load    = 1'b1;
            so_d    = 5'(i);
            bz_d    = busy_next;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + CNT_W'(1);
          end
        end
      end

      default: state_d = S_IDLE;
    endcase

    ov_d = load ? 1'b1 : (out_o.ready ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      zdiv_q  <= '1;
      hw_q    <= '0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        div_q[k] <= '0;
        ph_q[k]  <= '0;
      end
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      zdiv_q  <= zdiv_d;
      hw_q    <= hw_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
      div_q   <= div_d;
      ph_q    <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    if (load) begin
      st_q <= st_d;
      so_q <= so_d;
      fi_q <= fi_d;
      bz_q <= bz_d;
      la_q <= la_d;
    end
  end

  assign out_o.valid    = ov_q;
  assign out_o.status   = st_q;
  assign out_o.slot_out = so_q;
  assign out_o.fired    = fi_q;
  assign out_o.cpu_busy = bz_q;
  assign out_o.last     = la_q;

endmodule

// ===== src/slot_job_rate_divider_scheduler.sv =====
// Top level of the slot job rate divider scheduler.
//
// A table of job slots, each with an occupied mark, a 16-bit divider and a
// phase counter, driven by tick, add, remove and change-priority commands.
// Commands enter through a two-deep queue, so the input can take transfers
// while the engine works or a result waits, until the queue is full. The
// engine visits one slot per cycle while no result waits unaccepted at the
// output: a tick takes the command, visits each slot below the high-water
// mark and then issues the closing result, and yields one result per firing
// slot plus the closing one. An add scans to the first free slot, or reports a
// full table; remove and change act as soon as the command is taken. A result
// waiting unaccepted at the output register holds the engine.
module slot_job_rate_divider_scheduler import sjrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sjrd_in_if.sink     in_i,
  sjrd_out_if.source  out_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Decode and queue incoming commands.
  sjrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // Carry out queued commands against the slot table.
  sjrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_o       (out_o)
  );

`ifndef SYNTH
  // The engine takes a command only when the queue offers one.
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready |-> cmd_valid)
    else $error("engine popped an empty command queue");

  // A firing report is always a good, non-final result.
  a_fire_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.fired |-> (out_o.status == STAT_OK) && !out_o.last)
    else $error("firing result with bad status or last mark");

  // Table-full reports carry no slot.
  a_full_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == STAT_FULL) |-> (out_o.slot_out == '0) && out_o.last)
    else $error("table-full result carries a slot");
`endif

endmodule
